// ===== hdl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, codes and controller/datapath types of the first-fit
// byte allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int HEAP_MAX     = 4096;
  localparam int HEADER_BYTES = 12;
  localparam int FW           = 13;              // width of every count field
  localparam int LANE         = 8;               // map bits per memory word
  localparam int LANE_AW      = $clog2(LANE);
  localparam int MAP_DEPTH    = HEAP_MAX / LANE;
  localparam int MAP_AW       = $clog2(MAP_DEPTH);
  localparam int HEAP_AW      = $clog2(HEAP_MAX);
  localparam int PROD_W       = 2 * FW;
  localparam int NEED_W       = PROD_W + 1;
  localparam int IN_W         = 48;
  localparam int OUT_W        = 48;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_ZERO  = 3'd1;
  localparam logic [2:0] ST_SHORT = 3'd2;
  localparam logic [2:0] ST_NORUN = 3'd3;
  localparam logic [2:0] ST_NOBLK = 3'd4;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_DEC   = 11'b000_0000_0100,
    S_CHECK = 11'b000_0000_1000,
    S_SCAN  = 11'b000_0001_0000,
    S_HIT   = 11'b000_0010_0000,
    S_MARK  = 11'b000_0100_0000,
    S_SETRD = 11'b000_1000_0000,
    S_SETWR = 11'b001_0000_0000,
    S_POST  = 11'b010_0000_0000,
    S_WAIT  = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic       clr;      // clearing pass step
    logic       take;     // latch a new item
    logic       mult;     // form the payload product
    logic       look;     // read block start and payload size
    logic       grab;     // keep the payload size read back
    logic       hit_act;  // release the block start, set up the clear range
    logic       scan;     // first-fit scan step
    logic       mark;     // map update step
    logic       set_wr;   // write block start and payload size
    logic       rec;      // record a status code
    logic [2:0] code;
    logic       post;     // load the output register
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_alloc;
    logic is_free;
    logic is_query;
    logic zero_cnt;
    logic short_sp;
    logic hit;
    logic found;
    logic scan_end;
    logic mark_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// ffba_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer of the allocator: steps one item through decode, scan, map
// update and result posting.
// ----------------------------------------------------------------------------
module ffba_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  ffba_pkg::sts_t  sts,
  output ffba_pkg::cmd_t  cmd
);

  ffba_pkg::state_t state_r, state_nxt;

  assign in_tready = (state_r == ffba_pkg::S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ffba_pkg::S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ffba_pkg::S_IDLE;
        end
      end
      ffba_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = ffba_pkg::S_DEC;
        end
      end
      ffba_pkg::S_DEC: begin
        if (sts.is_alloc) begin
          if (sts.zero_cnt) begin
            cmd.rec   = 1'b1;
            cmd.code  = ffba_pkg::ST_ZERO;
            state_nxt = ffba_pkg::S_POST;
          end else begin
            cmd.mult  = 1'b1;
            state_nxt = ffba_pkg::S_CHECK;
          end
        end else if (sts.is_free || sts.is_query) begin
          cmd.look  = 1'b1;
          state_nxt = ffba_pkg::S_HIT;
        end else begin
          cmd.rec   = 1'b1;
          cmd.code  = ffba_pkg::ST_NOBLK;
          state_nxt = ffba_pkg::S_POST;
        end
      end
      ffba_pkg::S_CHECK: begin
        if (sts.short_sp) begin
          cmd.rec   = 1'b1;
          cmd.code  = ffba_pkg::ST_SHORT;
          state_nxt = ffba_pkg::S_POST;
        end else begin
          state_nxt = ffba_pkg::S_SCAN;
        end
      end
      ffba_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found) begin
          state_nxt = ffba_pkg::S_MARK;
        end else if (sts.scan_end) begin
          cmd.rec   = 1'b1;
          cmd.code  = ffba_pkg::ST_NORUN;
          state_nxt = ffba_pkg::S_POST;
        end
      end
      ffba_pkg::S_HIT: begin
        cmd.grab = 1'b1;
        if (!sts.hit) begin
          cmd.rec   = 1'b1;
          cmd.code  = ffba_pkg::ST_NOBLK;
          state_nxt = ffba_pkg::S_POST;
        end else if (sts.is_query) begin
          cmd.rec   = 1'b1;
          cmd.code  = ffba_pkg::ST_OK;
          state_nxt = ffba_pkg::S_POST;
        end else begin
          cmd.hit_act = 1'b1;
          state_nxt   = ffba_pkg::S_MARK;
        end
      end
      ffba_pkg::S_MARK: begin
        cmd.mark = 1'b1;
        if (sts.mark_last) begin
          if (sts.is_alloc) begin
            state_nxt = ffba_pkg::S_SETRD;
          end else begin
            cmd.rec   = 1'b1;
            cmd.code  = ffba_pkg::ST_OK;
            state_nxt = ffba_pkg::S_POST;
          end
        end
      end
      ffba_pkg::S_SETRD: begin
        state_nxt = ffba_pkg::S_SETWR;
      end
      ffba_pkg::S_SETWR: begin
        cmd.set_wr = 1'b1;
        cmd.rec    = 1'b1;
        cmd.code   = ffba_pkg::ST_OK;
        state_nxt  = ffba_pkg::S_POST;
      end
      ffba_pkg::S_POST: begin
        if (sts.out_free) begin
          cmd.post  = 1'b1;
          state_nxt = ffba_pkg::S_IDLE;
        end else begin
          state_nxt = ffba_pkg::S_WAIT;
        end
      end
      ffba_pkg::S_WAIT: begin
        if (sts.out_free) begin
          cmd.post  = 1'b1;
          state_nxt = ffba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ffba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffba_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/ffba_dp.sv =====
// ----------------------------------------------------------------------------
// ffba_dp
// Allocator datapath: used map, block start map, payload sizes, the
// first-fit scanner, the map updater and the output register.
// ----------------------------------------------------------------------------
module ffba_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ffba_pkg::FW-1:0]     cfg_wdata,
  input  logic [ffba_pkg::IN_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ffba_pkg::OUT_W-1:0]  out_tdata,
  input  ffba_pkg::cmd_t              cmd,
  output ffba_pkg::sts_t              sts
);

  localparam int FW = ffba_pkg::FW;
  localparam int MA = ffba_pkg::MAP_AW;
  localparam int LN = ffba_pkg::LANE;

  // configuration and totals
  logic [FW-1:0] heap_r, used_r;
  // latched item
  logic [1:0]    req_cmd_r;
  logic [FW-1:0] esz_r, cnt_r, off_r;
  logic [ffba_pkg::PROD_W-1:0] prod_r;
  // scan / mark
  logic [MA-1:0] clr_addr_r, scan_addr_r, daddr_r, pend_r;
  logic [MA:0]   mk_addr_r;
  logic          dv_r, pend_v_r, val_r;
  logic [FW-1:0] run_r, lo_r, hi_r, pay_r;
  logic [2:0]    code_r;
  logic          out_valid_r;
  logic [ffba_pkg::OUT_W-1:0] out_data_r;

  logic [FW-1:0] lim, lim_m1, space, need13, hi_m1, p_c, lo_free, total_free;
  logic [ffba_pkg::NEED_W-1:0] need;
  logic [MA-1:0] last_w;
  logic          issue;

  logic [LN-1:0] map_q, map_wdata, st_q, st_wdata;
  logic [MA-1:0] map_waddr, map_raddr, st_waddr, st_raddr;
  logic          map_we, st_we, pay_we;
  logic [FW-1:0] pay_q;

  logic [FW-1:0] run_c, spot_c, pos_c;
  logic          found_c, used_c;
  logic [LN-1:0] mark_word;
  logic [FW-1:0] pay_out, off_out;

  assign lim    = (heap_r > FW'(ffba_pkg::HEAP_MAX)) ? FW'(ffba_pkg::HEAP_MAX) : heap_r;
  assign lim_m1 = lim - 1'b1;
  assign space  = (used_r < lim) ? lim - used_r : '0;
  assign need   = {1'b0, prod_r} + ffba_pkg::NEED_W'(ffba_pkg::HEADER_BYTES);
  assign need13 = need[FW-1:0];
  assign hi_m1  = hi_r - 1'b1;
  assign last_w = hi_m1[ffba_pkg::HEAP_AW-1:ffba_pkg::LANE_AW];
  assign issue  = (mk_addr_r <= {1'b0, last_w});
  assign p_c    = lo_r + FW'(ffba_pkg::HEADER_BYTES);
  assign lo_free    = off_r - FW'(ffba_pkg::HEADER_BYTES);
  assign total_free = pay_q + FW'(ffba_pkg::HEADER_BYTES);

  // first-fit over one map word, bytes past the heap count as used
  always_comb begin
    run_c   = run_r;
    found_c = 1'b0;
    spot_c  = '0;
    pos_c   = '0;
    used_c  = 1'b0;
    for (int j = 0; j < LN; j++) begin
      pos_c  = {1'b0, daddr_r, ffba_pkg::LANE_AW'(j)};
      used_c = map_q[j] | (pos_c >= lim);
      if (used_c) begin
        run_c = '0;
      end else begin
        run_c = run_c + 1'b1;
      end
      if (!found_c && !used_c && (run_c == need13)) begin
        found_c = 1'b1;
        spot_c  = pos_c + 1'b1 - need13;
      end
    end
  end

  // set or clear the bits of the pending word that fall in [lo, hi)
  always_comb begin
    mark_word = map_q;
    for (int j = 0; j < LN; j++) begin
      if (({1'b0, pend_r, ffba_pkg::LANE_AW'(j)} >= lo_r) &&
          ({1'b0, pend_r, ffba_pkg::LANE_AW'(j)} < hi_r)) begin
        mark_word[j] = val_r;
      end
    end
  end

  // memory ports
  always_comb begin
    map_we    = 1'b0;
    map_waddr = pend_r;
    map_wdata = mark_word;
    if (cmd.clr) begin
      map_we    = 1'b1;
      map_waddr = clr_addr_r;
      map_wdata = '0;
    end else if (cmd.mark && pend_v_r) begin
      map_we = 1'b1;
    end
    map_raddr = cmd.mark ? mk_addr_r[MA-1:0] : scan_addr_r;

    st_we    = 1'b0;
    st_waddr = p_c[ffba_pkg::HEAP_AW-1:ffba_pkg::LANE_AW];
    st_wdata = st_q | (LN'(1) << p_c[ffba_pkg::LANE_AW-1:0]);
    if (cmd.clr) begin
      st_we    = 1'b1;
      st_waddr = clr_addr_r;
      st_wdata = '0;
    end else if (cmd.hit_act) begin
      st_we    = 1'b1;
      st_waddr = off_r[ffba_pkg::HEAP_AW-1:ffba_pkg::LANE_AW];
      st_wdata = st_q & ~(LN'(1) << off_r[ffba_pkg::LANE_AW-1:0]);
    end else if (cmd.set_wr) begin
      st_we = 1'b1;
    end
    st_raddr = cmd.look ? off_r[ffba_pkg::HEAP_AW-1:ffba_pkg::LANE_AW]
                        : p_c[ffba_pkg::HEAP_AW-1:ffba_pkg::LANE_AW];
    pay_we   = cmd.set_wr;
  end

  ffba_ram #(.WIDTH(LN), .DEPTH(ffba_pkg::MAP_DEPTH)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_q)
  );

  ffba_ram #(.WIDTH(LN), .DEPTH(ffba_pkg::MAP_DEPTH)) u_start (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_q)
  );

  ffba_ram #(.WIDTH(FW), .DEPTH(ffba_pkg::HEAP_MAX)) u_pay (
    .clk(clk), .we(pay_we), .waddr(p_c[ffba_pkg::HEAP_AW-1:0]),
    .wdata(prod_r[FW-1:0]), .raddr(off_r[ffba_pkg::HEAP_AW-1:0]), .rdata(pay_q)
  );

  // result fields
  always_comb begin
    pay_out = '0;
    off_out = '0;
    if (code_r == ffba_pkg::ST_OK) begin
      if (req_cmd_r == ffba_pkg::CMD_ALLOC) begin
        pay_out = prod_r[FW-1:0];
        off_out = p_c;
      end else begin
        pay_out = pay_r;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_r      <= '0;
      used_r      <= '0;
      clr_addr_r  <= '0;
      dv_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        heap_r <= cfg_wdata;
      end
      if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.take) begin
        dv_r <= 1'b0;
      end else if (cmd.scan) begin
        dv_r <= 1'b1;
      end
      if (cmd.hit_act || (cmd.scan && dv_r && found_c)) begin
        pend_v_r <= 1'b0;
      end else if (cmd.mark) begin
        pend_v_r <= issue;
      end
      if (cmd.hit_act) begin
        used_r <= (used_r > total_free) ? used_r - total_free : '0;
      end else if (cmd.set_wr) begin
        used_r <= used_r + need13;
      end
      if (cmd.post) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_cmd_r   <= in_tdata[1:0];
      esz_r       <= in_tdata[14:2];
      cnt_r       <= in_tdata[27:15];
      off_r       <= in_tdata[40:28];
      scan_addr_r <= '0;
      run_r       <= '0;
    end
    if (cmd.mult) begin
      prod_r <= (esz_r == '0) ? ffba_pkg::PROD_W'(cnt_r) : esz_r * cnt_r;
    end
    if (cmd.scan) begin
      scan_addr_r <= scan_addr_r + 1'b1;
      daddr_r     <= scan_addr_r;
      if (dv_r) begin
        run_r <= run_c;
      end
      if (dv_r && found_c) begin
        lo_r      <= spot_c;
        hi_r      <= spot_c + need13;
        val_r     <= 1'b1;
        mk_addr_r <= {1'b0, spot_c[ffba_pkg::HEAP_AW-1:ffba_pkg::LANE_AW]};
      end
    end
    if (cmd.grab) begin
      pay_r <= pay_q;
    end
    if (cmd.hit_act) begin
      lo_r      <= lo_free;
      hi_r      <= off_r + pay_q;
      val_r     <= 1'b0;
      mk_addr_r <= {1'b0, lo_free[ffba_pkg::HEAP_AW-1:ffba_pkg::LANE_AW]};
    end
    if (cmd.mark && issue) begin
      mk_addr_r <= mk_addr_r + 1'b1;
      pend_r    <= mk_addr_r[MA-1:0];
    end
    if (cmd.rec) begin
      code_r <= cmd.code;
    end
    if (cmd.post) begin
      out_data_r <= {6'b0, used_r, pay_out, off_out, code_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sts.clr_last  = (clr_addr_r == MA'(ffba_pkg::MAP_DEPTH - 1));
  assign sts.is_alloc  = (req_cmd_r == ffba_pkg::CMD_ALLOC);
  assign sts.is_free   = (req_cmd_r == ffba_pkg::CMD_FREE);
  assign sts.is_query  = (req_cmd_r == ffba_pkg::CMD_QUERY);
  assign sts.zero_cnt  = (cnt_r == '0);
  assign sts.short_sp  = (need > ffba_pkg::NEED_W'(space));
  assign sts.hit       = !off_r[FW-1] && st_q[off_r[ffba_pkg::LANE_AW-1:0]];
  assign sts.found     = dv_r && found_c;
  assign sts.scan_end  = dv_r && !found_c &&
                         (daddr_r == lim_m1[ffba_pkg::HEAP_AW-1:ffba_pkg::LANE_AW]);
  assign sts.mark_last = pend_v_r && (pend_r == last_w);
  assign sts.out_free  = !out_valid_r || out_tready;

endmodule

// ===== hdl/first_fit_byte_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_byte_allocator
// Byte-granular first-fit heap allocator with a separate used map.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command item per handshake (allocate, free, query size).
//   out_* : exactly one result item per command, in command order.
//   cfg_* : heap size register, written while the block is idle.
// After reset the block runs a clearing pass over every word of the used map
// and block start map (one 8-byte map word per cycle); in_tready stays low
// until it finishes. Configuration writes are taken at any time.
// Per item: a bad command or zero count posts after decode; a query, a miss
// or too little free space posts after the lookup or space check; a free
// clears the w 8-byte map words the block spans; an allocate scans s map
// words (up to 512) first-fit, then sets its w words, or posts a no-run.
// The scan and the map update each move one map word per cycle through
// the map memory's single read port.
// The result sits in an output register: a new item is accepted while it
// waits, but when the receiver stalls, the next result is held until the
// previous one is taken.
// ----------------------------------------------------------------------------
module first_fit_byte_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ffba_pkg::FW-1:0]     cfg_wdata,   // heap_bytes
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // command, element_size, element_count, block_offset
  input  logic [ffba_pkg::IN_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // status, payload_offset, payload_bytes, bytes_in_use
  output logic [ffba_pkg::OUT_W-1:0]  out_tdata
);

  ffba_pkg::cmd_t cmd;
  ffba_pkg::sts_t sts;

  // sequencer: one item at a time
  ffba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .sts(sts), .cmd(cmd)
  );

  // maps, scanner, updater and output register
  ffba_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .cmd(cmd), .sts(sts)
  );

  // a taken item blocks the input until its result is posted
  a_take_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input still ready after taking an item");

  // result never overwrites one that is still waiting
  a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post |-> sts.out_free)
    else $error("result posted over a pending one");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] <= ffba_pkg::ST_NOBLK))
    else $error("status code out of range");

  a_use_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[41:29] <= ffba_pkg::FW'(ffba_pkg::HEAP_MAX)))
    else $error("bytes in use above heap maximum");

endmodule
